// ----- src/shd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shd_pkg
// Shared types and constants of the static Huffman decoder.
// ----------------------------------------------------------------------------
package shd_pkg;

	localparam int NUM_SYMBOLS = 256;
	localparam int COUNT_BITS = 8;
	localparam int NODE_SLOTS = 2 * NUM_SYMBOLS + 1;
	localparam int NODE_BITS = $clog2(NODE_SLOTS);
	localparam int LEAF_BITS = $clog2(NUM_SYMBOLS + 1);
	localparam int WEIGHT_BITS = 16;
	localparam int INNER_BITS = $clog2(NUM_SYMBOLS);
	localparam logic [NODE_BITS-1:0] EOB_NODE = NODE_BITS'(NUM_SYMBOLS);
	localparam logic [NODE_BITS-1:0] FIRST_INNER = NODE_BITS'(NUM_SYMBOLS + 1);
	localparam logic [NODE_BITS-1:0] LAST_NODE = NODE_BITS'(NODE_SLOTS - 1);

	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_WRITE = 2'd1,
		FUNC_BUILD = 2'd2,
		FUNC_BIT   = 2'd3
	} func_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  symbol_index;
		logic [7:0]  symbol_count;
		logic        code_bit;
	} in_beat_t;

	typedef struct packed {
		logic        symbol_valid;
		logic [7:0]  symbol;
		logic        end_of_block;
		logic        tree_ready;
		logic        misuse;
	} out_beat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_BNODE,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_MERGE_A,
		ST_MERGE_B,
		ST_MERGE_C,
		ST_WALK,
		ST_WALK_RES,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start_clear;
		logic do_write;
		logic start_build;
		logic scan_start;
		logic scan_step;
		logic merge_a;
		logic merge_b;
		logic merge_c;
		logic finish_build;
		logic bit_misuse;
		logic walk_read;
		logic walk_res;
		logic load_simple;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic scan_done;
		logic pair_found;
		logic nodes_done;
		logic built;
	} sts_t;

endpackage

// ----- src/shd_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shd_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface shd_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/shd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shd_ctrl
// Controller: sequences clear, write, build and decode commands.
// ----------------------------------------------------------------------------
module shd_ctrl
	import shd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic [1:0] in_func,
	output logic     out_valid,
	input  logic     out_ready,
	input  sts_t     sts,
	output cmd_t     cmd
);

	state_t state_q, state_d;
	logic   take;

	assign in_ready = (state_q == ST_IDLE) || (state_q == ST_OUT && out_ready);
	assign take = in_valid && in_ready;
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE, ST_OUT: begin
				if (take) begin
					unique case (func_t'(in_func))
						FUNC_CLEAR: state_d = ST_CLEAR;
						FUNC_WRITE: state_d = ST_OUT;
						FUNC_BUILD: state_d = ST_BNODE;
						FUNC_BIT:   state_d = sts.built ? ST_WALK : ST_OUT;
						default:    state_d = ST_OUT;
					endcase
				end else if (state_q == ST_OUT && out_ready) begin
					state_d = ST_IDLE;
				end
			end
			ST_CLEAR:     state_d = sts.clear_done ? ST_OUT : ST_CLEAR;
			ST_BNODE:     state_d = sts.nodes_done ? ST_OUT : ST_SCAN;
			ST_SCAN:      state_d = sts.scan_done ? ST_SCAN_LAST : ST_SCAN;
			ST_SCAN_LAST: state_d = sts.pair_found ? ST_MERGE_A : ST_OUT;
			ST_MERGE_A:   state_d = ST_MERGE_B;
			ST_MERGE_B:   state_d = ST_MERGE_C;
			ST_MERGE_C:   state_d = ST_BNODE;
			ST_WALK:      state_d = ST_WALK_RES;
			ST_WALK_RES:  state_d = ST_OUT;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE, ST_OUT: begin
				if (take) begin
					unique case (func_t'(in_func))
						FUNC_CLEAR: cmd.start_clear = 1'b1;
						FUNC_WRITE: cmd.do_write = 1'b1;
						FUNC_BUILD: cmd.start_build = 1'b1;
						FUNC_BIT:   begin
							cmd.bit_misuse = !sts.built;
							cmd.walk_read = sts.built;
						end
						default:    cmd.load_simple = 1'b1;
					endcase
					cmd.load_simple = 1'b1;
				end
			end
			ST_BNODE:     cmd.scan_start = !sts.nodes_done;
			ST_SCAN:      cmd.scan_step = 1'b1;
			ST_SCAN_LAST: begin
				cmd.scan_step = 1'b1;
				cmd.finish_build = !sts.pair_found;
			end
			ST_MERGE_A:   cmd.merge_a = 1'b1;
			ST_MERGE_B:   cmd.merge_b = 1'b1;
			ST_MERGE_C:   cmd.merge_c = 1'b1;
			ST_WALK_RES:  cmd.walk_res = 1'b1;
			default:      cmd = '0;
		endcase
		if (state_q == ST_BNODE && sts.nodes_done) begin
			cmd.finish_build = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped while stalled");
	a_scan_merge: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE_A) |=> (state_q == ST_MERGE_B))
		else $error("merge sequence broken");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !in_ready)
		else $error("input taken during build");

endmodule

// ----- src/shd_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shd_datapath
// Weight and child memories, minimum search and tree walk.
// ----------------------------------------------------------------------------
module shd_datapath
	import shd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  in_beat_t  in_beat,
	input  cmd_t      cmd,
	output sts_t      sts,
	output out_beat_t out_beat
);

	logic [WEIGHT_BITS-1:0] weight_mem [NODE_SLOTS];
	logic [2*NODE_BITS-1:0] child_mem [NUM_SYMBOLS];
	logic [NUM_SYMBOLS:0]   wvalid_q;

	logic [NODE_BITS-1:0] root_q, walk_q, nf_q, scan_q, rd_idx_s1;
	logic [NODE_BITS-1:0] m1_q, m2_q, clr_q;
	logic [WEIGHT_BITS-1:0] w1_q, w2_q, rdata_q;
	logic v1_q, v2_q, built_q, rd_valid_s1, bit_q;
	logic [2*NODE_BITS-1:0] child_q;
	out_beat_t res_q;

	logic [NODE_BITS-1:0] rd_addr;
	logic [WEIGHT_BITS-1:0] w_eff;
	logic [INNER_BITS-1:0] kidx;
	logic wr_ok;
	logic [NODE_BITS-1:0] walk_nxt;
	logic walk_leaf, walk_eob;

	assign rd_addr = scan_q;
	assign w_eff = (rd_idx_s1 > EOB_NODE || wvalid_q[rd_idx_s1[LEAF_BITS-1:0]]) ?
		rdata_q : '0;
	assign kidx = INNER_BITS'(walk_q - FIRST_INNER);
	assign wr_ok = ({1'b0, in_beat.symbol_index} < 9'(NUM_SYMBOLS));

	always_comb begin
		walk_nxt = walk_q;
		if (walk_q > EOB_NODE) begin
			walk_nxt = bit_q ? child_q[2*NODE_BITS-1:NODE_BITS] : child_q[NODE_BITS-1:0];
		end
	end
	assign walk_leaf = (walk_nxt <= EOB_NODE);
	assign walk_eob = (walk_nxt == EOB_NODE);

	assign sts.clear_done = (clr_q == FIRST_INNER);
	assign sts.scan_done = (scan_q == nf_q);
	assign sts.pair_found = v2_q || (rd_valid_s1 && w_eff != '0 && v1_q);
	assign sts.nodes_done = (nf_q > LAST_NODE);
	assign sts.built = built_q;
	assign out_beat = res_q;

	always_ff @(posedge clk) begin
		rdata_q <= weight_mem[rd_addr];
		child_q <= child_mem[kidx];
		if (cmd.do_write && wr_ok) begin
			weight_mem[NODE_BITS'(in_beat.symbol_index)] <=
				WEIGHT_BITS'(in_beat.symbol_count & 8'((1 << COUNT_BITS) - 1));
		end else if (cmd.start_build) begin
			weight_mem[EOB_NODE] <= WEIGHT_BITS'(1);
		end else if (cmd.merge_a) begin
			weight_mem[nf_q] <= w1_q + w2_q;
			child_mem[INNER_BITS'(nf_q - FIRST_INNER)] <= {m2_q, m1_q};
		end else if (cmd.merge_b) begin
			weight_mem[m1_q] <= '0;
		end else if (cmd.merge_c) begin
			weight_mem[m2_q] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
			root_q <= EOB_NODE;
			walk_q <= EOB_NODE;
			built_q <= 1'b0;
			clr_q <= FIRST_INNER;
			nf_q <= '0;
			scan_q <= '0;
			rd_valid_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			m1_q <= '0;
			m2_q <= '0;
			w1_q <= '0;
			w2_q <= '0;
			bit_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (cmd.load_simple) begin
				res_q <= {1'b0, 8'd0, 1'b0, built_q && !cmd.start_clear, cmd.bit_misuse};
			end
			if (cmd.start_clear) begin
				clr_q <= '0;
				built_q <= 1'b0;
				walk_q <= root_q;
			end else if (clr_q <= EOB_NODE) begin
				wvalid_q[clr_q[LEAF_BITS-1:0]] <= 1'b0;
				clr_q <= clr_q + NODE_BITS'(1);
			end
			if (cmd.do_write && wr_ok) begin
				wvalid_q[LEAF_BITS'(in_beat.symbol_index)] <= 1'b1;
			end
			if (cmd.start_build) begin
				wvalid_q[EOB_NODE[LEAF_BITS-1:0]] <= 1'b1;
				nf_q <= FIRST_INNER;
				root_q <= EOB_NODE;
			end
			if (cmd.scan_start) begin
				scan_q <= '0;
				v1_q <= 1'b0;
				v2_q <= 1'b0;
				rd_valid_s1 <= 1'b0;
			end else if (cmd.scan_step) begin
				rd_valid_s1 <= (scan_q != nf_q);
				rd_idx_s1 <= scan_q;
				if (scan_q != nf_q) begin
					scan_q <= scan_q + NODE_BITS'(1);
				end
				if (rd_valid_s1 && w_eff != '0) begin
					if (!v1_q || w_eff < w1_q) begin
						m2_q <= m1_q; w2_q <= w1_q; v2_q <= v1_q;
						m1_q <= rd_idx_s1; w1_q <= w_eff; v1_q <= 1'b1;
					end else if (!v2_q || w_eff < w2_q) begin
						m2_q <= rd_idx_s1; w2_q <= w_eff; v2_q <= 1'b1;
					end
				end
			end
			if (cmd.merge_a) begin
				root_q <= nf_q;
				nf_q <= nf_q + NODE_BITS'(1);
			end
			if (cmd.finish_build) begin
				built_q <= 1'b1;
				walk_q <= root_q;
				res_q <= {1'b0, 8'd0, 1'b0, 1'b1, 1'b0};
			end
			if (cmd.walk_read) begin
				bit_q <= in_beat.code_bit;
			end
			if (cmd.walk_res) begin
				res_q <= {walk_leaf && !walk_eob,
					(walk_leaf && !walk_eob) ? walk_nxt[7:0] : 8'd0,
					walk_leaf && walk_eob, 1'b1, 1'b0};
				walk_q <= walk_leaf ? root_q : walk_nxt;
			end
		end
	end

	a_clear_stops: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_clear |=> !built_q)
		else $error("clear kept tree");
	a_sym_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_q.symbol_valid && res_q.end_of_block))
		else $error("symbol and end of block together");
	a_built_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_read |-> built_q)
		else $error("walk without tree");

endmodule

// ----- src/static_huffman_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// static_huffman_decoder
// Static Huffman decoder over 256 byte symbols and an end-of-block symbol.
// ----------------------------------------------------------------------------
// Commands arrive as beats on in_ch: clear counts, write a count, build the
// tree, or decode one code bit. Every command gives exactly one result beat
// on out_ch carrying the decoded symbol flags, tree_ready and misuse.
// A write goes straight to its result beat; a decoded bit first passes the
// walk and walk-result states, since the child memory read is registered
// before the edge is taken. A clear sweeps the 257 leaf valid bits, one per
// cycle. A build scans all existing nodes through the registered weight
// memory for every new node.
// A new command is taken in the cycle its predecessor's result is taken.
// When the receiver stalls, the result beat holds and no command enters.
// Reset empties the tree: root and walk point at the end-of-block leaf and
// all leaf weights read as zero.
// ----------------------------------------------------------------------------
module static_huffman_decoder
	import shd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	shd_stream_if.sink   in_ch,
	shd_stream_if.source out_ch
);

	cmd_t      cmd;
	sts_t      sts;
	in_beat_t  in_beat;
	out_beat_t out_beat;

	assign in_beat = in_ch.data;
	assign out_ch.data = out_beat;

	shd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_func   (in_beat.func),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	shd_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_beat  (in_beat),
		.cmd      (cmd),
		.sts      (sts),
		.out_beat (out_beat)
	);

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the static Huffman decoder.
// ----------------------------------------------------------------------------
// Commands go in as beats: clear, count writes, tree builds and code bits.
// A scoreboard class keeps its own copy of the counts and the tree and works
// out the result beat of every accepted command. Each result is checked
// field by field against the oldest open prediction. Both channels stall at
// random. Most sessions use small alphabets. One session uses every symbol
// and runs a full build.
// ----------------------------------------------------------------------------
module tb_top;
	import shd_pkg::*;

	localparam int LIMIT = 3000000;

	class huff_scoreboard;
		logic [15:0] weight [0:NODE_SLOTS-1];
		logic [NODE_BITS-1:0] kid0 [0:NUM_SYMBOLS-1];
		logic [NODE_BITS-1:0] kid1 [0:NUM_SYMBOLS-1];
		logic [NODE_BITS-1:0] root;
		logic [NODE_BITS-1:0] walk;
		logic        built;
		out_beat_t   pending [$];
		int          errors;

		function new();
			foreach (weight[i]) weight[i] = '0;
			foreach (kid0[i]) begin
				kid0[i] = '0;
				kid1[i] = '0;
			end
			root = EOB_NODE;
			walk = EOB_NODE;
			built = 1'b0;
			errors = 0;
		endfunction

		function void build_tree();
			int m1, m2, last;
			bit v1, v2;
			weight[EOB_NODE] = 16'd1;
			last = EOB_NODE;
			for (int nf = NUM_SYMBOLS + 1; nf < NODE_SLOTS; nf++) begin
				v1 = 0;
				v2 = 0;
				m1 = 0;
				m2 = 0;
				for (int i = 0; i < nf; i++) begin
					if (weight[i] == 0) continue;
					if (!v1 || weight[i] < weight[m1]) begin
						m2 = m1;
						v2 = v1;
						m1 = i;
						v1 = 1;
					end else if (!v2 || weight[i] < weight[m2]) begin
						m2 = i;
						v2 = 1;
					end
				end
				if (!v2) break;
				weight[nf] = weight[m1] + weight[m2];
				weight[m1] = '0;
				weight[m2] = '0;
				kid0[nf - NUM_SYMBOLS - 1] = NODE_BITS'(m1);
				kid1[nf - NUM_SYMBOLS - 1] = NODE_BITS'(m2);
				last = nf;
			end
			root = NODE_BITS'(last);
			walk = NODE_BITS'(last);
			built = 1'b1;
		endfunction

		function void note(in_beat_t b);
			out_beat_t r;
			logic [NODE_BITS-1:0] nxt;
			r = '0;
			case (func_t'(b.func))
				FUNC_CLEAR: begin
					for (int i = 0; i <= NUM_SYMBOLS; i++) weight[i] = '0;
					built = 1'b0;
					walk = root;
				end
				FUNC_WRITE: begin
					weight[b.symbol_index] = {8'd0, b.symbol_count};
				end
				FUNC_BUILD: begin
					build_tree();
				end
				default: begin
					if (!built) begin
						r.misuse = 1'b1;
					end else begin
						nxt = walk;
						if (walk > EOB_NODE)
							nxt = b.code_bit ? kid1[walk - EOB_NODE - 1]
								: kid0[walk - EOB_NODE - 1];
						if (nxt <= EOB_NODE) begin
							if (nxt == EOB_NODE) begin
								r.end_of_block = 1'b1;
							end else begin
								r.symbol_valid = 1'b1;
								r.symbol = nxt[7:0];
							end
							walk = root;
						end else begin
							walk = nxt;
						end
					end
				end
			endcase
			r.tree_ready = built;
			pending.push_back(r);
		endfunction

		task report(string what, int want, int got);
			$display("mismatch: %s expected %0h got %0h at %0t", what, want, got, $time);
			errors++;
		endtask

		task check(out_beat_t got);
			out_beat_t want;
			if (pending.size() == 0) begin
				report("result with nothing pending", 0, int'(got));
			end else begin
				want = pending.pop_front();
				if (got.symbol_valid !== want.symbol_valid)
					report("symbol_valid", want.symbol_valid, got.symbol_valid);
				if (got.symbol !== want.symbol)
					report("symbol", want.symbol, got.symbol);
				if (got.end_of_block !== want.end_of_block)
					report("end_of_block", want.end_of_block, got.end_of_block);
				if (got.tree_ready !== want.tree_ready)
					report("tree_ready", want.tree_ready, got.tree_ready);
				if (got.misuse !== want.misuse)
					report("misuse", want.misuse, got.misuse);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	int   hold;
	int   cycles;

	huff_scoreboard sb = new();

	shd_stream_if #(.payload_t(in_beat_t))  in_ch ();
	shd_stream_if #(.payload_t(out_beat_t)) out_ch ();

	static_huffman_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		int g;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold <= 0;
		end else if (out_ch.valid && out_ch.ready) begin
			sb.check(out_ch.data);
			g = calm ? 0 : $urandom_range(0, 6);
			if (g == 0) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b0;
				hold <= g;
			end
		end else if (hold > 0) begin
			hold <= hold - 1;
			if (hold == 1) out_ch.ready <= 1'b1;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	int sent;

	task push_cmd(func_t f, int idx, int cnt, int cb);
		in_beat_t b;
		int gap;
		b.func = f;
		b.symbol_index = 8'(idx);
		b.symbol_count = 8'(cnt);
		b.code_bit = 1'(cb);
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= b;
		do @(posedge clk); while (!in_ch.ready);
		sb.note(b);
		sent++;
	endtask

	task drain_results();
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task push_noise();
		push_cmd(func_t'($urandom_range(0, 3)), $urandom_range(0, 255),
			$urandom_range(0, 255), $urandom_range(0, 1));
	endtask

	task push_bits(int n);
		for (int i = 0; i < n; i++) push_cmd(FUNC_BIT, $urandom, $urandom, $urandom_range(0, 1));
	endtask

	task code_session(int nsym);
		if ($urandom_range(0, 5) != 0) push_cmd(FUNC_CLEAR, $urandom, $urandom, $urandom);
		if ($urandom_range(0, 4) == 0) push_bits(1);
		for (int i = 0; i < nsym; i++)
			push_cmd(FUNC_WRITE, $urandom_range(0, 255),
				($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 255), $urandom);
		push_cmd(FUNC_BUILD, $urandom, $urandom, $urandom);
		for (int i = 0; i < $urandom_range(15, 45); i++) begin
			if ($urandom_range(0, 9) == 0) push_noise();
			else push_bits(1);
		end
		if ($urandom_range(0, 3) == 0) begin
			push_cmd(FUNC_WRITE, $urandom_range(0, 255), $urandom_range(1, 255), $urandom);
			push_bits(5);
			push_cmd(FUNC_BUILD, $urandom, $urandom, $urandom);
			push_bits(5);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		calm = 1'b0;
		sent = 0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_cmd(FUNC_BIT, 0, 0, 1);
		push_cmd(FUNC_CLEAR, 255, 255, 0);
		push_cmd(FUNC_WRITE, 0, 255, 0);
		push_cmd(FUNC_WRITE, 255, 1, 1);
		push_cmd(FUNC_WRITE, 128, 0, 0);
		push_cmd(FUNC_WRITE, 85, 170, 1);
		push_cmd(FUNC_BUILD, 0, 0, 0);
		push_cmd(FUNC_BIT, 0, 0, 0);
		push_cmd(FUNC_BIT, 0, 0, 1);
		push_cmd(FUNC_BIT, 0, 0, 1);
		push_cmd(FUNC_BIT, 0, 0, 0);
		push_cmd(FUNC_BIT, 255, 255, 1);
		push_cmd(FUNC_WRITE, 170, 85, 0);
		push_cmd(FUNC_BIT, 0, 0, 1);
		push_cmd(FUNC_BUILD, 0, 0, 0);
		push_cmd(FUNC_BIT, 0, 0, 0);
		push_cmd(FUNC_BIT, 0, 0, 1);
		push_cmd(FUNC_CLEAR, 0, 0, 0);
		push_cmd(FUNC_BIT, 0, 0, 1);
		push_cmd(FUNC_BUILD, 0, 0, 0);
		push_cmd(FUNC_BIT, 0, 0, 1);
		push_cmd(FUNC_BIT, 0, 0, 0);

		drain_results();
		calm = 1'b1;
		push_cmd(FUNC_CLEAR, 0, 0, 0);
		for (int i = 0; i < NUM_SYMBOLS; i++)
			push_cmd(FUNC_WRITE, i, $urandom_range(1, 255), $urandom);
		calm = 1'b0;
		push_cmd(FUNC_BUILD, 0, 0, 0);
		push_bits(80);

		while (sent < 1510) begin
			calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 7) == 0) code_session($urandom_range(13, 40));
			else code_session($urandom_range(1, 12));
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
src/shd_pkg.sv
src/shd_stream_if.sv
src/shd_ctrl.sv
src/shd_datapath.sv
src/static_huffman_decoder.sv
bench/tb_top.sv
